[hdl/see_pkg.sv]
// shared types, constants and fixed-point helpers for the stack expression evaluator
// no dependencies
`default_nettype none
package see_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int VAR_COUNT   = 64;

    localparam int VAL_W = 64;
    localparam int ENT_W = VAL_W + 1;
    localparam int OP_W  = 5;
    localparam int VIX_W = 6;
    localparam int KND_W = 2;
    localparam int ERR_W = 3;
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int VA_W  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    localparam logic [VAL_W-1:0] SIGN_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] POS_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] ONE_Q    = 64'h0000_0001_0000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_PUSHC  = 5'd0,
        OP_PUSHV  = 5'd1,
        OP_EVAL   = 5'd2,
        OP_ADD    = 5'd3,
        OP_SUB    = 5'd4,
        OP_MUL    = 5'd5,
        OP_DIV    = 5'd6,
        OP_NEG    = 5'd7,
        OP_GT     = 5'd8,
        OP_LT     = 5'd9,
        OP_GE     = 5'd10,
        OP_LE     = 5'd11,
        OP_EQ     = 5'd12,
        OP_NE     = 5'd13,
        OP_AND    = 5'd14,
        OP_OR     = 5'd15,
        OP_NOT    = 5'd16,
        OP_ASSIGN = 5'd17,
        OP_PRINT  = 5'd18
    } op_t;

    typedef enum logic [KND_W-1:0] {
        KIND_DONE  = 2'd0,
        KIND_PRINT = 2'd1,
        KIND_ERR   = 2'd2
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE   = 3'd0,
        ERR_OVER   = 3'd1,
        ERR_UNDER  = 3'd2,
        ERR_UNDEF  = 3'd3,
        ERR_NOTVAR = 3'd4,
        ERR_DIVZ   = 3'd5
    } err_t;

    function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] x);
        return x[VAL_W-1] ? (VAL_W'(0) - x) : x;
    endfunction

    function automatic logic [VAL_W-1:0] from_sign_mag(input logic neg,
                                                       input logic [VAL_W-1:0] mag,
                                                       input logic ovf);
        logic [VAL_W-1:0] r;
        if (neg)
        begin
            r = (ovf || mag > SIGN_MIN) ? SIGN_MIN : (VAL_W'(0) - mag);
        end
        else
        begin
            r = (ovf || mag > POS_MAX) ? POS_MAX : mag;
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] s;
        s = a + b;
        if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
        begin
            s = a[VAL_W-1] ? SIGN_MIN : POS_MAX;
        end
        return s;
    endfunction

    function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] d;
        d = a - b;
        if (a[VAL_W-1] != b[VAL_W-1] && d[VAL_W-1] != a[VAL_W-1])
        begin
            d = a[VAL_W-1] ? SIGN_MIN : POS_MAX;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

[hdl/see_if.sv]
// valid/ready channel interfaces for instructions and results
// depends on see_pkg
`default_nettype none
interface see_in_if;
    logic                             valid;
    logic                             ready;
    logic [see_pkg::OP_W-1:0]         op;
    logic signed [see_pkg::VAL_W-1:0] value;
    logic [see_pkg::VIX_W-1:0]        var_index;

    modport source (output valid, output op, output value, output var_index, input ready);
    modport sink   (input valid, input op, input value, input var_index, output ready);
endinterface

interface see_out_if;
    logic                             valid;
    logic                             ready;
    logic [see_pkg::KND_W-1:0]        kind;
    logic signed [see_pkg::VAL_W-1:0] out_value;
    logic [see_pkg::ERR_W-1:0]        error_code;

    modport source (output valid, output kind, output out_value, output error_code, input ready);
    modport sink   (input valid, input kind, input out_value, input error_code, output ready);
endinterface
`default_nettype wire

[hdl/see_ram.sv]
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none
module see_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]     wdata,
    output logic      [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[hdl/stack_expression_evaluator_top.sv]
// Stack-machine expression evaluator over signed Q32.32 values with saturating arithmetic.
// One instruction per input transaction, one result transaction per instruction. The operand
// stack and the variable values live in single-port rams; defined marks are flip-flops.
// Pushes write the stack straight from idle; other operations first read the top entry and
// binary ones then the entry below; multiply sums four 32x32 partial products, one per cycle,
// and divide uses the radix-2 divider that forms one quotient bit per cycle over 64 bits.
// An error ends the instruction early and empties the stack. A new instruction is taken
// while the previous result still waits on the output register. No clearing pass after reset.
// depends on see_pkg, see_if, see_ram
`default_nettype none
module stack_expression_evaluator_top (
    input  wire logic clk,
    input  wire logic rst_n,
    see_in_if.sink    in_item,
    see_out_if.source result
);
    localparam int VW = see_pkg::VAL_W;
    localparam int EW = see_pkg::ENT_W;
    localparam int SP = see_pkg::SP_W;
    localparam int SA = see_pkg::SA_W;
    localparam int VA = see_pkg::VA_W;

    typedef enum logic [3:0] {
        S_IDLE, S_POP1, S_POP2, S_VAR, S_MUL, S_MULF, S_DIVI, S_DIV, S_DIVF, S_FIN
    } state_t;

    state_t                   state_reg, state_next;
    logic [SP-1:0]            sp_reg, sp_next;
    logic [see_pkg::OP_W-1:0] op_reg, op_next;
    logic [EW-1:0]            y_reg, y_next;
    logic [VW-1:0]            a_reg, a_next, b_reg, b_next;
    logic                     neg_reg, neg_next;
    logic [127:0]             acc_reg, acc_next;
    logic [VW:0]              r_reg, r_next;
    logic [VW-1:0]            q_reg, q_next, d_reg, d_next;
    logic [5:0]               cnt_reg, cnt_next;
    logic [see_pkg::KND_W-1:0] res_kind_reg, res_kind_next, out_kind_reg, out_kind_next;
    logic [VW-1:0]            res_val_reg, res_val_next, out_val_reg, out_val_next;
    logic [see_pkg::ERR_W-1:0] res_err_reg, res_err_next, out_err_reg, out_err_next;
    logic                     out_valid_reg, out_valid_next;
    logic [see_pkg::VAR_COUNT-1:0] defined_reg, defined_next;

    logic          st_we, var_we;
    logic [SA-1:0] st_addr;
    logic [EW-1:0] st_wdata, st_rdata;
    logic [VA-1:0] var_addr;
    logic [VW-1:0] var_wdata, var_rdata;

    logic [SP-1:0] sp_m1, sp_m2;
    assign sp_m1 = sp_reg - SP'(1);
    assign sp_m2 = sp_reg - SP'(2);

    logic [31:0]   mul_pa, mul_pb;
    logic [63:0]   mul_prod;
    logic [1:0]    mul_sh;
    assign mul_pa   = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign mul_pb   = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
    assign mul_prod = mul_pa * mul_pb;
    assign mul_sh   = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};

    logic [VW:0] div_rs;
    assign div_rs = {r_reg[VW-1:0], d_reg[VW-1]};

    see_ram #(.WIDTH(EW), .DEPTH(see_pkg::STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (st_wdata),
        .rdata (st_rdata)
    );

    see_ram #(.WIDTH(VW), .DEPTH(see_pkg::VAR_COUNT)) u_vars (
        .clk   (clk),
        .we    (var_we),
        .addr  (var_addr),
        .wdata (var_wdata),
        .rdata (var_rdata)
    );

    assign in_item.ready     = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.kind       = out_kind_reg;
    assign result.out_value  = out_val_reg;
    assign result.error_code = out_err_reg;

    always_comb
    begin
        logic [see_pkg::ERR_W-1:0] err;
        logic                      bin_done;
        logic [VW-1:0]             bin_res;
        logic [VW-1:0]             pa, pb, ua, ub;
        logic                      t;

        err      = see_pkg::ERR_NONE;
        bin_done = 1'b0;
        bin_res  = '0;
        t        = 1'b0;
        pa       = st_rdata[VW-1:0];
        pb       = y_reg[VW-1:0];
        ua       = see_pkg::magnitude(pa);
        ub       = see_pkg::magnitude(pb);

        state_next     = state_reg;
        sp_next        = sp_reg;
        op_next        = op_reg;
        y_next         = y_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        q_next         = q_reg;
        d_next         = d_reg;
        cnt_next       = cnt_reg;
        res_kind_next  = res_kind_reg;
        res_val_next   = res_val_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_val_next   = out_val_reg;
        out_err_next   = out_err_reg;
        defined_next   = defined_reg;

        st_we     = 1'b0;
        st_addr   = sp_m1[SA-1:0];
        st_wdata  = '0;
        var_we    = 1'b0;
        var_addr  = y_reg[VA-1:0];
        var_wdata = st_rdata[VW-1:0];

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_item.valid)
                begin
                    op_next       = in_item.op;
                    res_kind_next = see_pkg::KIND_DONE;
                    res_val_next  = '0;
                    res_err_next  = see_pkg::ERR_NONE;
                    state_next    = S_FIN;
                    unique case (in_item.op)
                        see_pkg::OP_PUSHC, see_pkg::OP_PUSHV:
                        begin
                            if (sp_reg >= SP'(see_pkg::STACK_DEPTH))
                            begin
                                err = see_pkg::ERR_OVER;
                            end
                            else
                            begin
                                st_we    = 1'b1;
                                st_addr  = sp_reg[SA-1:0];
                                st_wdata = (in_item.op == see_pkg::OP_PUSHV)
                                         ? {1'b1, VW'(in_item.var_index)}
                                         : {1'b0, in_item.value};
                                sp_next  = sp_reg + SP'(1);
                            end
                        end
                        see_pkg::OP_EVAL, see_pkg::OP_ADD, see_pkg::OP_SUB, see_pkg::OP_MUL,
                        see_pkg::OP_DIV, see_pkg::OP_NEG, see_pkg::OP_GT, see_pkg::OP_LT,
                        see_pkg::OP_GE, see_pkg::OP_LE, see_pkg::OP_EQ, see_pkg::OP_NE,
                        see_pkg::OP_AND, see_pkg::OP_OR, see_pkg::OP_NOT,
                        see_pkg::OP_ASSIGN, see_pkg::OP_PRINT:
                        begin
                            if (sp_reg == '0)
                            begin
                                err = see_pkg::ERR_UNDER;
                            end
                            else
                            begin
                                state_next = S_POP1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP1:
            begin
                y_next = st_rdata;
                unique case (op_reg)
                    see_pkg::OP_EVAL:
                    begin
                        if (!st_rdata[VW] || st_rdata[VW-1:0] >= VW'(see_pkg::VAR_COUNT))
                        begin
                            err = see_pkg::ERR_NOTVAR;
                        end
                        else if (!defined_reg[st_rdata[VA-1:0]])
                        begin
                            err = see_pkg::ERR_UNDEF;
                        end
                        else
                        begin
                            var_addr   = st_rdata[VA-1:0];
                            state_next = S_VAR;
                        end
                    end
                    see_pkg::OP_NEG:
                    begin
                        st_we      = 1'b1;
                        st_wdata   = {1'b0, (pa == see_pkg::SIGN_MIN) ? see_pkg::POS_MAX
                                                                      : (VW'(0) - pa)};
                        state_next = S_FIN;
                    end
                    see_pkg::OP_NOT:
                    begin
                        st_we      = 1'b1;
                        st_wdata   = {1'b0, (pa == '0) ? see_pkg::ONE_Q : VW'(0)};
                        state_next = S_FIN;
                    end
                    see_pkg::OP_PRINT:
                    begin
                        sp_next       = sp_m1;
                        res_kind_next = see_pkg::KIND_PRINT;
                        res_val_next  = pa;
                        state_next    = S_FIN;
                    end
                    default:
                    begin
                        if (op_reg == see_pkg::OP_DIV && pa == '0)
                        begin
                            err = see_pkg::ERR_DIVZ;
                        end
                        else if (sp_reg < SP'(2))
                        begin
                            err = see_pkg::ERR_UNDER;
                        end
                        else
                        begin
                            st_addr    = sp_m2[SA-1:0];
                            state_next = S_POP2;
                        end
                    end
                endcase
            end
            S_VAR:
            begin
                st_we      = 1'b1;
                st_wdata   = {1'b0, var_rdata};
                state_next = S_FIN;
            end
            S_POP2:
            begin
                a_next   = ua;
                b_next   = ub;
                neg_next = pa[VW-1] ^ pb[VW-1];
                unique case (op_reg)
                    see_pkg::OP_ASSIGN:
                    begin
                        if (!y_reg[VW] || y_reg[VW-1:0] >= VW'(see_pkg::VAR_COUNT))
                        begin
                            err = see_pkg::ERR_NOTVAR;
                        end
                        else
                        begin
                            var_we                          = 1'b1;
                            defined_next[y_reg[VA-1:0]]     = 1'b1;
                            bin_done                        = 1'b1;
                            bin_res                         = pa;
                        end
                    end
                    see_pkg::OP_MUL:
                    begin
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                    see_pkg::OP_DIV:
                    begin
                        state_next = S_DIVI;
                    end
                    see_pkg::OP_ADD:
                    begin
                        bin_done = 1'b1;
                        bin_res  = see_pkg::sat_add(pa, pb);
                    end
                    see_pkg::OP_SUB:
                    begin
                        bin_done = 1'b1;
                        bin_res  = see_pkg::sat_sub(pa, pb);
                    end
                    default:
                    begin
                        unique case (op_reg)
                            see_pkg::OP_GT:  t = $signed(pb) < $signed(pa);
                            see_pkg::OP_LT:  t = $signed(pa) < $signed(pb);
                            see_pkg::OP_GE:  t = !($signed(pa) < $signed(pb));
                            see_pkg::OP_LE:  t = !($signed(pb) < $signed(pa));
                            see_pkg::OP_EQ:  t = (pa == pb);
                            see_pkg::OP_NE:  t = (pa != pb);
                            see_pkg::OP_AND: t = (pa != '0) && (pb != '0);
                            default:         t = (pa != '0) || (pb != '0);
                        endcase
                        bin_done = 1'b1;
                        bin_res  = t ? see_pkg::ONE_Q : VW'(0);
                    end
                endcase
            end
            S_MUL:
            begin
                acc_next = acc_reg + ({64'b0, mul_prod} << {mul_sh, 5'b0});
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = S_MULF;
                end
            end
            S_MULF:
            begin
                bin_done = 1'b1;
                bin_res  = see_pkg::from_sign_mag(neg_reg, acc_reg[95:32], |acc_reg[127:96]);
            end
            S_DIVI:
            begin
                if ({32'b0, a_reg} >= {b_reg, 32'b0})
                begin
                    bin_done = 1'b1;
                    bin_res  = see_pkg::from_sign_mag(neg_reg, '0, 1'b1);
                end
                else
                begin
                    r_next     = {33'b0, a_reg[63:32]};
                    d_next     = {a_reg[31:0], 32'b0};
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rs >= {1'b0, b_reg})
                begin
                    r_next = div_rs - {1'b0, b_reg};
                    q_next = {q_reg[VW-2:0], 1'b1};
                end
                else
                begin
                    r_next = div_rs;
                    q_next = {q_reg[VW-2:0], 1'b0};
                end
                d_next   = {d_reg[VW-2:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = S_DIVF;
                end
            end
            S_DIVF:
            begin
                bin_done = 1'b1;
                bin_res  = see_pkg::from_sign_mag(neg_reg, q_reg, 1'b0);
            end
            S_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_val_next   = res_val_reg;
                    out_err_next   = res_err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (bin_done)
        begin
            st_we      = 1'b1;
            st_addr    = sp_m2[SA-1:0];
            st_wdata   = {1'b0, bin_res};
            sp_next    = sp_m1;
            state_next = S_FIN;
        end

        if (err != see_pkg::ERR_NONE)
        begin
            st_we         = 1'b0;
            res_kind_next = see_pkg::KIND_ERR;
            res_val_next  = '0;
            res_err_next  = err;
            sp_next       = '0;
            state_next    = S_FIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            op_reg        <= '0;
            y_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            r_reg         <= '0;
            q_reg         <= '0;
            d_reg         <= '0;
            cnt_reg       <= '0;
            res_kind_reg  <= '0;
            res_val_reg   <= '0;
            res_err_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= '0;
            out_val_reg   <= '0;
            out_err_reg   <= '0;
            defined_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            op_reg        <= op_next;
            y_reg         <= y_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            r_reg         <= r_next;
            q_reg         <= q_next;
            d_reg         <= d_next;
            cnt_reg       <= cnt_next;
            res_kind_reg  <= res_kind_next;
            res_val_reg   <= res_val_next;
            res_err_reg   <= res_err_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_val_reg   <= out_val_next;
            out_err_reg   <= out_err_next;
            defined_reg   <= defined_next;
        end
    end

    // the stack pointer never passes the stack depth
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP'(see_pkg::STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // an error result always leaves an empty stack
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && res_kind_reg == see_pkg::KIND_ERR) |-> sp_reg == '0)
        else $error("stack not emptied on error");

    // divider partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> r_reg < {1'b0, b_reg})
        else $error("divider remainder out of range");

    // a result transaction is only loaded from the finish state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result loaded outside finish");
endmodule
`default_nettype wire

[tb/see_scoreboard.sv]
// scoreboard for the stack expression evaluator: predicts each result from accepted instructions
// depends on see_pkg
`timescale 1ns / 1ps
class see_scoreboard;
    typedef struct packed {
        logic [see_pkg::KND_W-1:0] kind;
        logic [63:0]               val;
        logic [see_pkg::ERR_W-1:0] err;
    } outcome_t;

    logic        ent_ref [see_pkg::STACK_DEPTH];
    logic [63:0] ent_val [see_pkg::STACK_DEPTH];
    int          depth;
    logic [63:0] var_val [see_pkg::VAR_COUNT];
    bit          var_def [see_pkg::VAR_COUNT];
    outcome_t    pending[$];
    int          mismatches;
    int          checked;
    int          prints;
    int          errors;

    function new();
        depth = 0;
        mismatches = 0;
        checked = 0;
        prints = 0;
        errors = 0;
        foreach (var_def[i]) var_def[i] = 0;
    endfunction

    function automatic bit slt(logic [63:0] a, logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [63:0] clamp(logic neg, logic [127:0] mag);
        if (neg)
        begin
            if (mag > 128'h8000_0000_0000_0000) return see_pkg::SIGN_MIN;
            return 64'd0 - mag[63:0];
        end
        if (mag > 128'h7FFF_FFFF_FFFF_FFFF) return see_pkg::POS_MAX;
        return mag[63:0];
    endfunction

    function automatic logic [63:0] abs64(logic [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > $signed({1'b0, see_pkg::POS_MAX})) return see_pkg::POS_MAX;
        if (s < $signed({1'b1, see_pkg::SIGN_MIN})) return see_pkg::SIGN_MIN;
        return s[63:0];
    endfunction

    function automatic outcome_t execute(logic [4:0] op, logic [63:0] v, logic [5:0] vi);
        outcome_t o;
        logic [63:0] a, b, r;
        logic        bref;
        logic [127:0] p;
        bit t;
        int e;
        e = 0;
        o = '0;
        r = 0;
        case (op)
            see_pkg::OP_PUSHC, see_pkg::OP_PUSHV:
            begin
                if (depth >= see_pkg::STACK_DEPTH) e = see_pkg::ERR_OVER;
                else
                begin
                    ent_ref[depth] = (op == see_pkg::OP_PUSHV);
                    ent_val[depth] = (op == see_pkg::OP_PUSHV) ? {58'd0, vi} : v;
                    depth++;
                end
            end
            see_pkg::OP_EVAL:
            begin
                if (depth == 0) e = see_pkg::ERR_UNDER;
                else
                begin
                    depth--;
                    if (!ent_ref[depth] || ent_val[depth] >= see_pkg::VAR_COUNT)
                        e = see_pkg::ERR_NOTVAR;
                    else if (!var_def[ent_val[depth]]) e = see_pkg::ERR_UNDEF;
                    else
                    begin
                        ent_val[depth] = var_val[ent_val[depth]];
                        ent_ref[depth] = 0;
                        depth++;
                    end
                end
            end
            see_pkg::OP_NEG, see_pkg::OP_NOT:
            begin
                if (depth == 0) e = see_pkg::ERR_UNDER;
                else
                begin
                    a = ent_val[depth-1];
                    if (op == see_pkg::OP_NEG)
                        ent_val[depth-1] = (a == see_pkg::SIGN_MIN) ? see_pkg::POS_MAX : 64'd0 - a;
                    else
                        ent_val[depth-1] = (a == 0) ? see_pkg::ONE_Q : 64'd0;
                    ent_ref[depth-1] = 0;
                end
            end
            see_pkg::OP_ASSIGN:
            begin
                if (depth < 2) e = see_pkg::ERR_UNDER;
                else
                begin
                    bref = ent_ref[depth-1];
                    b = ent_val[depth-1];
                    a = ent_val[depth-2];
                    depth -= 2;
                    if (!bref || b >= see_pkg::VAR_COUNT) e = see_pkg::ERR_NOTVAR;
                    else
                    begin
                        var_val[b] = a;
                        var_def[b] = 1;
                        ent_ref[depth] = 0;
                        ent_val[depth] = a;
                        depth++;
                    end
                end
            end
            see_pkg::OP_PRINT:
            begin
                if (depth == 0) e = see_pkg::ERR_UNDER;
                else
                begin
                    depth--;
                    o.kind = see_pkg::KIND_PRINT;
                    o.val = ent_val[depth];
                end
            end
            default:
            begin
                if (op >= see_pkg::OP_ADD && op <= see_pkg::OP_OR)
                begin
                    if (depth == 0) e = see_pkg::ERR_UNDER;
                    else if (op == see_pkg::OP_DIV && ent_val[depth-1] == 0)
                        e = see_pkg::ERR_DIVZ;
                    else if (depth == 1) e = see_pkg::ERR_UNDER;
                    else
                    begin
                        b = ent_val[depth-1];
                        a = ent_val[depth-2];
                        depth -= 2;
                        case (op)
                            see_pkg::OP_ADD: r = sadd(a, b);
                            see_pkg::OP_SUB:
                            begin
                                if (b == see_pkg::SIGN_MIN)
                                    r = a[63] ? a - b : see_pkg::POS_MAX;
                                else r = sadd(a, 64'd0 - b);
                            end
                            see_pkg::OP_MUL:
                            begin
                                p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
                                r = clamp(a[63] ^ b[63], p >> 32);
                            end
                            see_pkg::OP_DIV:
                            begin
                                p = ({64'd0, abs64(a)} << 32) / {64'd0, abs64(b)};
                                r = clamp(a[63] ^ b[63], p);
                            end
                            default:
                            begin
                                case (op)
                                    see_pkg::OP_GT: t = slt(b, a);
                                    see_pkg::OP_LT: t = slt(a, b);
                                    see_pkg::OP_GE: t = !slt(a, b);
                                    see_pkg::OP_LE: t = !slt(b, a);
                                    see_pkg::OP_EQ: t = (a == b);
                                    see_pkg::OP_NE: t = (a != b);
                                    see_pkg::OP_AND: t = (a != 0 && b != 0);
                                    default: t = (a != 0 || b != 0);
                                endcase
                                r = t ? see_pkg::ONE_Q : 64'd0;
                            end
                        endcase
                        ent_ref[depth] = 0;
                        ent_val[depth] = r;
                        depth++;
                    end
                end
            end
        endcase
        if (e != 0)
        begin
            depth = 0;
            o.kind = see_pkg::KIND_ERR;
            o.val = 0;
            o.err = e[2:0];
        end
        return o;
    endfunction

    function void note_instruction(logic [4:0] op, logic [63:0] v, logic [5:0] vi);
        pending.push_back(execute(op, v, vi));
    endfunction

    function void check_result(logic [1:0] kind, logic [63:0] val, logic [2:0] err);
        outcome_t x;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result kind=%0d", kind);
            return;
        end
        x = pending.pop_front();
        if (kind == see_pkg::KIND_PRINT) prints++;
        if (kind == see_pkg::KIND_ERR) errors++;
        if (x.kind !== kind || x.val !== val || x.err !== err)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch #%0d: exp kind=%0d val=%h err=%0d, got kind=%0d val=%h err=%0d",
                         checked, x.kind, x.val, x.err, kind, val, err);
        end
    endfunction
endclass

[tb/stack_expression_evaluator_top_tb.sv]
// testbench top for the stack expression evaluator: directed and random instruction streams
// depends on see_pkg, see_if, see_scoreboard and the evaluator rtl
`timescale 1ns / 1ps
module stack_expression_evaluator_top_tb;
    localparam int OP_UNUSED_LO = int'(see_pkg::OP_PRINT) + 1;
    localparam int OP_UNUSED_HI = 31;

    logic clk;
    logic rst_n;
    see_in_if  in_item();
    see_out_if result();
    see_scoreboard board;
    int  idle_cycles;
    bit  hold_off;
    int  sent;

    stack_expression_evaluator_top dut (
        .clk(clk), .rst_n(rst_n), .in_item(in_item.sink), .result(result.source)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_item.valid && in_item.ready)
            board.note_instruction(in_item.op, in_item.value, in_item.var_index);
        if (rst_n && result.valid && result.ready)
            board.check_result(result.kind, result.out_value, result.error_code);
        if ((in_item.valid && in_item.ready) || (result.valid && result.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 20000)
        begin
            $display("** stack_expression_evaluator_top: FAILED **");
            $finish;
        end
    end

    // receiver stall pattern plus one long hold-off
    initial
    begin
        int phase;
        phase = 0;
        result.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_off) result.ready <= 0;
            else if (phase % 300 < 100) result.ready <= 1;
            else result.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send(logic [4:0] op, logic [63:0] v, logic [5:0] vi);
        in_item.op <= op;
        in_item.value <= v;
        in_item.var_index <= vi;
        in_item.valid <= 1;
        @(posedge clk);
        while (!in_item.ready) @(posedge clk);
        sent++;
        @(negedge clk);
        if ($urandom_range(0, 4) == 0)
        begin
            in_item.valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    function automatic logic [63:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return see_pkg::SIGN_MIN;
            1: return see_pkg::POS_MAX;
            2: return {32'($urandom_range(0, 20)) - 32'd10, 32'd0};
            3: return {{32{1'b0}}, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic wait_empty();
        in_item.valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    initial
    begin
        logic [5:0] slot;
        int k, n;
        board = new();
        in_item.valid = 0;
        in_item.op = 0;
        in_item.value = 0;
        in_item.var_index = 0;
        hold_off = 0;
        sent = 0;
        idle_cycles = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // directed: underflow, divide by zero without dividend, extremes, arithmetic ops
        send(see_pkg::OP_PRINT, '0, '0);
        send(see_pkg::OP_PUSHC, '0, '0);
        send(see_pkg::OP_DIV, '0, '0);
        send(see_pkg::OP_PUSHV, '0, 6'd63);
        send(see_pkg::OP_EVAL, '0, '0);
        send(see_pkg::OP_PUSHC, '0, '0);
        send(see_pkg::OP_EVAL, '0, '0);
        send(see_pkg::OP_PUSHC, see_pkg::SIGN_MIN, '0);
        send(see_pkg::OP_NEG, '0, '0);
        send(see_pkg::OP_PUSHC, see_pkg::SIGN_MIN, '0);
        send(see_pkg::OP_SUB, '0, '0);
        send(see_pkg::OP_PUSHC, see_pkg::POS_MAX, '0);
        send(see_pkg::OP_MUL, '0, '0);
        send(see_pkg::OP_PUSHC, 64'h0000_0000_0000_0001, '0);
        send(see_pkg::OP_DIV, '0, '0);
        send(see_pkg::OP_PUSHV, '0, 6'd5);
        send(see_pkg::OP_ADD, '0, '0);
        send(see_pkg::OP_PUSHV, '0, 6'd7);
        send(see_pkg::OP_ASSIGN, '0, '0);
        send(see_pkg::OP_PUSHV, '0, 6'd7);
        send(see_pkg::OP_EVAL, '0, '0);
        send(see_pkg::OP_NOT, '0, '0);
        send(see_pkg::OP_PRINT, '0, '0);
        send(5'(OP_UNUSED_HI), '0, '0);
        send(see_pkg::OP_PUSHC, rnd_val(), '0);
        send(see_pkg::OP_ASSIGN, '0, '0);
        send(see_pkg::OP_PUSHV, '0, 6'd3);
        send(see_pkg::OP_ASSIGN, '0, '0);
        for (k = 0; k < 256; k++) send(see_pkg::OP_PUSHC, rnd_val(), '0);
        send(see_pkg::OP_PUSHC, '0, '0);
        // long receiver hold-off while instructions keep coming
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            for (k = 0; k < 30; k++) send(see_pkg::OP_PUSHC, rnd_val(), '0);
        join
        send(see_pkg::OP_PRINT, '0, '0);
        // random expression sequences
        while (sent < 800)
        begin
            n = $urandom_range(2, 8);
            for (k = 0; k < n; k++)
                send(see_pkg::OP_PUSHC, rnd_val(), '0);
            for (k = 0; k < n + 2; k++)
            begin
                case ($urandom_range(0, 9))
                    0: send(see_pkg::OP_PUSHV, '0, 6'($urandom_range(0, 63)));
                    1: send(see_pkg::OP_EVAL, '0, '0);
                    2:
                    begin
                        slot = 6'($urandom_range(0, 63));
                        send(see_pkg::OP_PUSHV, '0, slot);
                        send(see_pkg::OP_ASSIGN, '0, '0);
                    end
                    3: send(5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), rnd_val(),
                            6'($urandom()));
                    4: send(see_pkg::OP_PRINT, '0, '0);
                    default: send(5'($urandom_range(int'(see_pkg::OP_ADD),
                                                    int'(see_pkg::OP_NOT))), '0, '0);
                endcase
            end
            if ($urandom_range(0, 2) == 0) send(see_pkg::OP_PRINT, '0, '0);
        end
        wait_empty();
        $display("covered %0d instructions, %0d results checked (%0d printed, %0d errors)",
                 sent, board.checked, board.prints, board.errors);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("** stack_expression_evaluator_top: PASSED **");
        else
            $display("** stack_expression_evaluator_top: FAILED **");
        $finish;
    end
endmodule
